/* hw/rtl/lsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the LSB stego stream decoder.
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int HEADER_BYTES_DEF    = 54;
    localparam int MAX_MAGIC_CHARS_DEF = 8;
    localparam int BITS_PER_CHAR       = 8;
    localparam int WORD_BITS           = 32;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_CHARS  = 1'd1;

    localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
    localparam logic [63:0] MAGIC_CHARS_RST  = 64'h0000_0000_0000_2A23;

    typedef enum logic [2:0] {
        KIND_EXT_LEN  = 3'd0,
        KIND_EXT_CHAR = 3'd1,
        KIND_FILE_SZ  = 3'd2,
        KIND_DATA     = 3'd3,
        KIND_MISMATCH = 3'd4
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [31:0] value;
        logic        last;
    } result_t;

endpackage

/* hw/rtl/lsd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_core
// Decode state: header skip, LSB packing, magic check and length tracking.
// Updates on each accepted byte and presents at most one result.
// ----------------------------------------------------------------------------
module lsd_core #(
    parameter int HEADER_BYTES    = lsd_pkg::HEADER_BYTES_DEF,
    parameter int MAX_MAGIC_CHARS = lsd_pkg::MAX_MAGIC_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             image_bit,
    input  logic             restart,
    input  logic [3:0]       magic_length,
    input  logic [63:0]      magic_chars,
    output lsd_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_EXTCHR = 3'd3,
        PH_SIZE   = 3'd4,
        PH_DATA   = 3'd5,
        PH_HALT   = 3'd6
    } phase_t;

    localparam logic [5:0] HDR_LIMIT = 6'(HEADER_BYTES);
    localparam logic [3:0] MAGIC_MAX = 4'(MAX_MAGIC_CHARS);
    localparam logic [4:0] CHAR_TOP  = 5'(lsd_pkg::BITS_PER_CHAR - 1);
    localparam logic [4:0] WORD_TOP  = 5'(lsd_pkg::WORD_BITS - 1);

    logic [5:0]  header_count_reg, header_count_next;
    phase_t      phase_reg, phase_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [31:0] bit_shift_reg, bit_shift_next;
    logic [31:0] items_left_reg, items_left_next;
    logic [3:0]  magic_index_reg, magic_index_next;
    logic        magic_ok_reg, magic_ok_next;

    logic [3:0]  magic_len;

    // Effective magic length: zero counts as one, clipped at the maximum
    always_comb
    begin
        if (magic_length == 4'd0)
            magic_len = 4'd1;
        else if (magic_length > MAGIC_MAX)
            magic_len = MAGIC_MAX;
        else
            magic_len = magic_length;
    end

    always_comb
    begin
        logic        go;
        logic [4:0]  top;
        logic [31:0] word;
        logic [31:0] cnt;
        logic [7:0]  expect_chr;

        header_count_next = header_count_reg;
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        bit_shift_next    = bit_shift_reg;
        items_left_next   = items_left_reg;
        magic_index_next  = magic_index_reg;
        magic_ok_next     = magic_ok_reg;
        result            = '0;
        go                = 1'b1;
        top               = CHAR_TOP;
        word              = '0;
        cnt               = '0;
        expect_chr        = '0;

        if (restart)
        begin
            header_count_next = '0;
            phase_next        = PH_HEADER;
            bit_count_next    = '0;
            bit_shift_next    = '0;
            items_left_next   = '0;
            magic_index_next  = '0;
            magic_ok_next     = 1'b1;
        end

        if (phase_next == PH_HEADER)
        begin
            if (header_count_next < HDR_LIMIT)
            begin
                header_count_next = header_count_next + 6'd1;
                if (header_count_next >= HDR_LIMIT)
                    phase_next = PH_MAGIC;
                go = 1'b0;
            end
            else
            begin
                phase_next = PH_MAGIC;
            end
        end

        if (go && phase_next != PH_HALT)
        begin
            top  = (phase_next == PH_EXTLEN || phase_next == PH_SIZE) ? WORD_TOP : CHAR_TOP;
            word = bit_shift_next | (32'(image_bit) << bit_count_next);
            if (bit_count_next != top)
            begin
                bit_count_next = bit_count_next + 5'd1;
                bit_shift_next = word;
            end
            else
            begin
                bit_count_next = '0;
                bit_shift_next = '0;
                // bit 31 set counts as zero items
                cnt = word[31] ? 32'd0 : word;
                case (phase_next)
                    PH_MAGIC:
                    begin
                        expect_chr = magic_chars[{magic_index_next[2:0], 3'b000} +: 8];
                        if (word[7:0] != expect_chr)
                            magic_ok_next = 1'b0;
                        magic_index_next = magic_index_next + 4'd1;
                        if (magic_index_next >= magic_len)
                        begin
                            if (!magic_ok_next)
                            begin
                                phase_next   = PH_HALT;
                                result.valid = 1'b1;
                                result.kind  = lsd_pkg::KIND_MISMATCH;
                                result.last  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_EXTLEN;
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        items_left_next = cnt;
                        phase_next      = (cnt != 32'd0) ? PH_EXTCHR : PH_SIZE;
                        result.valid    = 1'b1;
                        result.kind     = lsd_pkg::KIND_EXT_LEN;
                        result.value    = word;
                    end
                    PH_EXTCHR:
                    begin
                        items_left_next = items_left_next - 32'd1;
                        if (items_left_next == 32'd0)
                            phase_next = PH_SIZE;
                        result.valid = 1'b1;
                        result.kind  = lsd_pkg::KIND_EXT_CHAR;
                        result.value = {24'd0, word[7:0]};
                    end
                    PH_SIZE:
                    begin
                        items_left_next = cnt;
                        phase_next      = (cnt != 32'd0) ? PH_DATA : PH_HALT;
                        result.valid    = 1'b1;
                        result.kind     = lsd_pkg::KIND_FILE_SZ;
                        result.value    = word;
                        result.last     = (cnt == 32'd0);
                    end
                    default:
                    begin
                        items_left_next = items_left_next - 32'd1;
                        if (items_left_next == 32'd0)
                            phase_next = PH_HALT;
                        result.valid = 1'b1;
                        result.kind  = lsd_pkg::KIND_DATA;
                        result.value = {24'd0, word[7:0]};
                        result.last  = (items_left_next == 32'd0);
                    end
                endcase
            end
        end

        if (!accept)
            result.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= '0;
            phase_reg        <= PH_HEADER;
            bit_count_reg    <= '0;
            bit_shift_reg    <= '0;
            items_left_reg   <= '0;
            magic_index_reg  <= '0;
            magic_ok_reg     <= 1'b1;
        end
        else if (accept)
        begin
            header_count_reg <= header_count_next;
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            bit_shift_reg    <= bit_shift_next;
            items_left_reg   <= items_left_next;
            magic_index_reg  <= magic_index_next;
            magic_ok_reg     <= magic_ok_next;
        end
    end

endmodule

/* hw/rtl/lsb_stego_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_stream_decoder
// LSB steganography decoder: skips the image header, packs pixel LSBs into
// magic, extension length/chars, file size and data bytes.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------
//  byte    | byte_valid / byte_ready  | image_byte, restart
//  result  | result_valid/result_ready| kind, value, last
//  cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One byte per cycle; a result shows in the cycle after the byte that completes it.
// Throughput is set by the single output register: byte_ready drops only while
// a result sits there and result_ready is low.
// Reset clears decode state and loads the default magic; no clearing pass.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module lsb_stego_stream_decoder #(
    parameter int HEADER_BYTES    = lsd_pkg::HEADER_BYTES_DEF,
    parameter int MAX_MAGIC_CHARS = lsd_pkg::MAX_MAGIC_CHARS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             byte_valid,
    output logic                             byte_ready,
    input  logic [7:0]                       image_byte,
    input  logic                             restart,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [2:0]                       kind,
    output logic [31:0]                      value,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [3:0]       magic_length_reg;
    logic [63:0]      magic_chars_reg;
    logic             result_valid_reg;
    logic [2:0]       kind_reg;
    logic [31:0]      value_reg;
    logic             last_reg;
    logic             accept;
    lsd_pkg::result_t core_result;

    assign cfg_ready  = 1'b1;
    assign byte_ready = !result_valid_reg || result_ready;
    assign accept     = byte_valid && byte_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_length_reg <= lsd_pkg::MAGIC_LENGTH_RST;
            magic_chars_reg  <= lsd_pkg::MAGIC_CHARS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lsd_pkg::CFG_MAGIC_LENGTH: magic_length_reg <= cfg_data[3:0];
                lsd_pkg::CFG_MAGIC_CHARS:  magic_chars_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    lsd_core #(
        .HEADER_BYTES    (HEADER_BYTES),
        .MAX_MAGIC_CHARS (MAX_MAGIC_CHARS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .image_bit    (image_byte[0]),
        .restart      (restart),
        .magic_length (magic_length_reg),
        .magic_chars  (magic_chars_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (core_result.valid)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_result.valid)
        begin
            kind_reg  <= core_result.kind;
            value_reg <= core_result.value;
            last_reg  <= core_result.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;
    assign last         = last_reg;

endmodule

/* hw/rtl/lsd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [2:0]  kind,
    input logic [31:0] value,
    input logic        last
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(value) && $stable(kind)
            && $stable(last))
        else $error("result changed while stalled");

    a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == lsd_pkg::KIND_MISMATCH |-> last && value == 32'd0)
        else $error("mismatch result malformed");

    a_byte_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == lsd_pkg::KIND_EXT_CHAR || kind == lsd_pkg::KIND_DATA)
            |-> value[31:8] == 24'd0)
        else $error("char/data value exceeds 8 bits");

    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == lsd_pkg::KIND_EXT_LEN || kind == lsd_pkg::KIND_EXT_CHAR)
            |-> !last)
        else $error("last flagged before file size");

endmodule

bind lsb_stego_stream_decoder lsd_checker u_lsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .value        (value),
    .last         (last)
);

/* test/tb_lsb_stego_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_stego_stream_decoder
// Streams stego images (header, LSB-coded magic, extension and file payload)
// into the decoder and checks every result against a scoreboard that decodes
// the same bytes. Covers restarts, bad magic, negative and zero sizes,
// magic length clamping, back-pressure and register changes between images.
// ----------------------------------------------------------------------------
module tb_lsb_stego_stream_decoder;
    import lsd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {
        ST_HEADER, ST_MAGIC, ST_EXT_LEN, ST_EXT_CHAR, ST_FILE_SZ, ST_DATA, ST_DONE
    } dec_phase_e;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic        last;
    } dec_result_t;

    // Scoreboard: decodes accepted bytes and holds the results still owed.
    class stego_scoreboard;
        logic [3:0]  magic_len;
        logic [63:0] magic_word;
        int          hdr_cnt;
        dec_phase_e  ph;
        int          bit_cnt;
        logic [31:0] shift_word;
        logic [31:0] remaining;
        int          magic_idx;
        bit          magic_good;
        dec_result_t pending_results[$];
        int          errors;
        int          results_seen;

        function new();
            magic_len    = MAGIC_LENGTH_RST;
            magic_word   = MAGIC_CHARS_RST;
            errors       = 0;
            results_seen = 0;
            clear_decode();
        endfunction

        function void clear_decode();
            hdr_cnt    = 0;
            ph         = ST_HEADER;
            bit_cnt    = 0;
            shift_word = '0;
            remaining  = '0;
            magic_idx  = 0;
            magic_good = 1'b1;
        endfunction

        function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
            if (idx == CFG_MAGIC_LENGTH)
                magic_len = data[3:0];
            else if (idx == CFG_MAGIC_CHARS)
                magic_word = data;
        endfunction

        function void push_result(kind_t k, logic [31:0] v, logic l);
            dec_result_t r;
            r.kind  = k;
            r.value = v;
            r.last  = l;
            pending_results.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b, logic rs);
            int          need;
            int          mlen;
            logic [31:0] word;
            if (rs)
                clear_decode();
            if (ph == ST_HEADER)
            begin
                if (hdr_cnt < HEADER_BYTES_DEF)
                begin
                    hdr_cnt++;
                    if (hdr_cnt >= HEADER_BYTES_DEF)
                        ph = ST_MAGIC;
                    return;
                end
                ph = ST_MAGIC;
            end
            if (ph == ST_DONE)
                return;
            need = (ph == ST_EXT_LEN || ph == ST_FILE_SZ) ? WORD_BITS : BITS_PER_CHAR;
            shift_word |= 32'(b[0]) << bit_cnt;
            if (bit_cnt + 1 < need)
            begin
                bit_cnt++;
                return;
            end
            word       = shift_word;
            shift_word = '0;
            bit_cnt    = 0;
            case (ph)
                ST_MAGIC:
                begin
                    if (magic_len == 0)
                        mlen = 1;
                    else if (magic_len > MAX_MAGIC_CHARS_DEF)
                        mlen = MAX_MAGIC_CHARS_DEF;
                    else
                        mlen = magic_len;
                    if (magic_idx < 8 && word[7:0] != magic_word[8*magic_idx +: 8])
                        magic_good = 1'b0;
                    magic_idx++;
                    if (magic_idx >= mlen)
                    begin
                        if (!magic_good)
                        begin
                            ph = ST_DONE;
                            push_result(KIND_MISMATCH, '0, 1'b1);
                        end
                        else
                            ph = ST_EXT_LEN;
                    end
                end
                ST_EXT_LEN:
                begin
                    remaining = word[31] ? '0 : word;
                    if (remaining != 0)
                        ph = ST_EXT_CHAR;
                    else
                        ph = ST_FILE_SZ;
                    push_result(KIND_EXT_LEN, word, 1'b0);
                end
                ST_EXT_CHAR:
                begin
                    remaining--;
                    if (remaining == 0)
                        ph = ST_FILE_SZ;
                    push_result(KIND_EXT_CHAR, {24'd0, word[7:0]}, 1'b0);
                end
                ST_FILE_SZ:
                begin
                    remaining = word[31] ? '0 : word;
                    if (remaining != 0)
                        ph = ST_DATA;
                    else
                        ph = ST_DONE;
                    push_result(KIND_FILE_SZ, word, remaining == 0);
                end
                default:
                begin
                    remaining--;
                    if (remaining == 0)
                        ph = ST_DONE;
                    push_result(KIND_DATA, {24'd0, word[7:0]}, remaining == 0);
                end
            endcase
        endfunction

        function void check_result(logic [2:0] k, logic [31:0] v, logic l);
            dec_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0h last %0b", k, v, l);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            results_seen++;
            if (k !== exp_r.kind)
            begin
                $error("kind: expected %0d, actual %0d", exp_r.kind, k);
                errors++;
            end
            if (v !== exp_r.value)
            begin
                $error("value: expected %0h, actual %0h", exp_r.value, v);
                errors++;
            end
            if (l !== exp_r.last)
            begin
                $error("last: expected %0b, actual %0b", exp_r.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   byte_valid   = 1'b0;
    logic                   byte_ready;
    logic [7:0]             image_byte   = '0;
    logic                   restart      = 1'b0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [2:0]             kind;
    logic [31:0]            value;
    logic                   last;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    stego_scoreboard sb = new();
    logic [8:0]      img_q[$];    // {restart, byte}
    int              tx_idle_pct = 31;
    int              rx_idle_pct = 51;
    int              hold_left   = 0;
    int              items_sent  = 0;
    int              cycle_count = 0;

    lsb_stego_stream_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .image_byte   (image_byte),
        .restart      (restart),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .value        (value),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.apply_reg(cfg_index, cfg_data);
            if (byte_valid && byte_ready)
                sb.take_byte(image_byte, restart);
            if (result_valid && result_ready)
                sb.check_result(kind, value, last);
        end
    end

    // result sink; a long hold-off is counted down here
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic int word_count(logic [31:0] w);
        return w[31] ? 0 : int'(w);
    endfunction

    function automatic logic [31:0] pick_size();
        if ($urandom_range(0, 9) == 0)
            return {1'b1, 31'($urandom)};
        return 32'($urandom_range(0, 5));
    endfunction

    task automatic push_bits(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++)
            img_q.push_back({1'b0, 7'($urandom), w[i]});
    endtask

    // One image: header, magic, ext, size, capped payload (if magic good), junk.
    task automatic build_image(input bit bad_magic, input logic [31:0] ext_word,
                               input logic [31:0] size_word, input int data_cap);
        int         mlen;
        int         bad_k;
        int         n;
        logic [7:0] ch;
        img_q.push_back({1'b1, 8'($urandom)});
        for (int i = 1; i < HEADER_BYTES_DEF; i++)
            img_q.push_back({1'b0, 8'($urandom)});
        if (sb.magic_len == 0)
            mlen = 1;
        else if (sb.magic_len > MAX_MAGIC_CHARS_DEF)
            mlen = MAX_MAGIC_CHARS_DEF;
        else
            mlen = sb.magic_len;
        bad_k = $urandom_range(0, mlen - 1);
        for (int k = 0; k < mlen; k++)
        begin
            ch = sb.magic_word[8*k +: 8];
            if (bad_magic && k == bad_k)
                ch ^= 8'($urandom_range(1, 255));
            push_bits(32'(ch), BITS_PER_CHAR);
        end
        if (!bad_magic)
        begin
            push_bits(ext_word, WORD_BITS);
            repeat (word_count(ext_word))
                push_bits(32'($urandom), BITS_PER_CHAR);
            push_bits(size_word, WORD_BITS);
            n = word_count(size_word);
            if (n > data_cap)
                n = data_cap;
            repeat (n)
                push_bits(32'($urandom), BITS_PER_CHAR);
        end
        repeat ($urandom_range(1, 6))
            img_q.push_back({1'b0, 8'($urandom)});
    endtask

    task automatic truncate_image(input int keep);
        while (img_q.size() > keep)
            void'(img_q.pop_back());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic rs);
        // idle profile follows the number of bytes sent so far
        if (items_sent < 480)
        begin
            tx_idle_pct = 31;
            rx_idle_pct = 51;
        end
        else if (items_sent < 960)
        begin
            tx_idle_pct = 51;
            rx_idle_pct = 31;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        image_byte <= b;
        restart    <= rs;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_image();
        logic [8:0] e;
        while (img_q.size() != 0)
        begin
            e = img_q.pop_front();
            send_byte(e[7:0], e[8]);
        end
    endtask

    // stop sending and wait for every owed result, plus the output stage
    task automatic settle();
        byte_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reconfigure(input logic [3:0] mlen, input logic [63:0] chars);
        settle();
        cfg_write(CFG_MAGIC_LENGTH, 64'(mlen));
        cfg_write(CFG_MAGIC_CHARS, chars);
    endtask

    initial
    begin
        int          pick;
        int          image_no;
        logic [3:0]  mlen;
        logic [31:0] ext_w;
        logic [31:0] size_w;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default magic straight out of reset
        build_image(1'b0, 32'd2, 32'd3, 64);
        send_image();
        build_image(1'b1, 32'd0, 32'd0, 64);
        send_image();

        // length 0 acts as 1; all-zero magic byte still compared
        reconfigure(4'd0, 64'd0);
        build_image(1'b0, 32'd0, 32'd0, 64);
        send_image();

        // length 15 clamps to 8; negative extension length and file size
        reconfigure(4'd15, '1);
        build_image(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 64);
        send_image();

        reconfigure(4'd8, {$urandom, $urandom});
        build_image(1'b1, 32'd0, 32'd0, 64);
        send_image();

        // restarts: inside the magic, inside a huge payload, inside the header
        reconfigure(4'd1, {$urandom, $urandom});
        build_image(1'b0, 32'd1, 32'd2, 64);
        truncate_image(HEADER_BYTES_DEF + 5);
        send_image();
        build_image(1'b0, 32'd0, 32'h7FFF_FFFF, 3);
        send_image();
        build_image(1'b0, 32'd1, 32'd1, 64);
        truncate_image(10);
        send_image();
        build_image(1'b0, 32'd1, 32'd1, 64);
        send_image();

        image_no = 0;
        while (items_sent < 1450)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    mlen = 4'($urandom);
                else
                    mlen = 4'($urandom_range(1, 8));
                reconfigure(mlen, {$urandom, $urandom});
            end
            // back-pressure long enough to fill the output stage and stall input
            if (image_no == 0)
                hold_left = 600;
            pick   = $urandom_range(0, 99);
            ext_w  = pick_size();
            size_w = pick_size();
            build_image(pick < 10, ext_w, size_w, 64);
            if (pick >= 90)
                truncate_image($urandom_range(1, img_q.size() - 1));
            send_image();
            image_no++;
        end

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
